// ----- hw/rtl/asp_pkg.sv -----
// ----------------------------------------------------------------------------
// Actuator safety supervisor package
// Item, result and configuration types, command codes, register indexes and
// reset values shared by the supervisor modules.
// ----------------------------------------------------------------------------
package asp_pkg;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 24;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_SET      = 2'd1,
    CMD_STOP     = 2'd2,
    CMD_PRESENCE = 2'd3
  } cmd_t;

  localparam logic [CfgIndexWidth-1:0] REG_LEASE_DEFAULT    = 3'd0;
  localparam logic [CfgIndexWidth-1:0] REG_PRESENCE_TIMEOUT = 3'd1;
  localparam logic [CfgIndexWidth-1:0] REG_PING_INTERVAL    = 3'd2;
  localparam logic [CfgIndexWidth-1:0] REG_RUN_LIMIT        = 3'd3;
  localparam logic [CfgIndexWidth-1:0] REG_REARM_GAP        = 3'd4;

  localparam logic [15:0] LEASE_DEFAULT_RESET    = 16'd500;
  localparam logic [19:0] PRESENCE_TIMEOUT_RESET = 20'd3000;
  localparam logic [19:0] PING_INTERVAL_RESET    = 20'd1500;
  localparam logic [23:0] RUN_LIMIT_RESET        = 24'd60000;
  localparam logic [19:0] REARM_GAP_RESET        = 20'd2000;

  localparam logic [15:0] SAT16 = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] now_ms;
    logic        ssr_write;
    logic        ssr_value;
    logic        dimmer_write;
    logic [7:0]  dimmer_value;
    logic [15:0] ttl_ms;
  } asp_in_t;

  typedef struct packed {
    logic        ssr_on;
    logic [7:0]  dimmer_level;
    logic        locked_out;
    logic        peer_lost;
    logic [15:0] lease_left_ms;
    logic [15:0] run_time_ms;
    logic        ev_lease_expired;
    logic        ev_presence_lost;
    logic        ev_ping_request;
    logic        ev_lockout;
    logic        ev_refused;
  } asp_out_t;

  typedef struct packed {
    logic [15:0] lease_default_ms;
    logic [19:0] presence_timeout_ms;
    logic [19:0] ping_interval_ms;
    logic [23:0] run_limit_ms;
    logic [19:0] rearm_gap_ms;
  } asp_cfg_t;

  function automatic logic [15:0] sat16(input logic [31:0] v);
    sat16 = (v[31:16] != 16'd0) ? SAT16 : v[15:0];
  endfunction

endpackage

// ----- hw/rtl/asp_cfg.sv -----
// ----------------------------------------------------------------------------
// Supervisor configuration registers
// Holds the five timing limits, written through a plain indexed write port.
// ----------------------------------------------------------------------------
module asp_cfg (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [asp_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  logic [asp_pkg::CfgDataWidth-1:0]     cfg_data,
  output asp_pkg::asp_cfg_t                    cfg
);
  import asp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lease_default_ms    <= LEASE_DEFAULT_RESET;
      cfg.presence_timeout_ms <= PRESENCE_TIMEOUT_RESET;
      cfg.ping_interval_ms    <= PING_INTERVAL_RESET;
      cfg.run_limit_ms        <= RUN_LIMIT_RESET;
      cfg.rearm_gap_ms        <= REARM_GAP_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEASE_DEFAULT:    cfg.lease_default_ms    <= cfg_data[15:0];
        REG_PRESENCE_TIMEOUT: cfg.presence_timeout_ms <= cfg_data[19:0];
        REG_PING_INTERVAL:    cfg.ping_interval_ms    <= cfg_data[19:0];
        REG_RUN_LIMIT:        cfg.run_limit_ms        <= cfg_data[23:0];
        REG_REARM_GAP:        cfg.rearm_gap_ms        <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- hw/rtl/asp_core.sv -----
// ----------------------------------------------------------------------------
// Supervisor decision logic
// Holds the supervisor state and computes one result per item combinationally.
// ----------------------------------------------------------------------------
module asp_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  asp_pkg::asp_in_t  item,
  input  asp_pkg::asp_cfg_t cfg,
  output asp_pkg::asp_out_t res
);
  import asp_pkg::*;

  logic        switch_level, switch_level_next;
  logic [7:0]  dim_level, dim_level_next;
  logic        lease_armed, lease_armed_next;
  logic [31:0] lease_deadline, lease_deadline_next;
  logic        run_valid, run_valid_next;
  logic [31:0] run_start, run_start_next;
  logic        off_valid, off_valid_next;
  logic [31:0] off_start, off_start_next;
  logic        heard_valid, heard_valid_next;
  logic [31:0] last_heard, last_heard_next;
  logic        lost_flag, lost_flag_next;
  logic        ping_valid, ping_valid_next;
  logic [31:0] last_ping, last_ping_next;
  logic        lockout_flag, lockout_flag_next;

  always_comb begin
    logic [31:0] now;
    logic [31:0] ttl;
    logic [31:0] d_old;
    logic [31:0] d_new;
    logic [31:0] off_age;
    logic        ev_lease, ev_lost, ev_ping, ev_lock, ev_ref;

    now      = item.now_ms;
    ttl      = '0;
    ev_lease = 1'b0;
    ev_lost  = 1'b0;
    ev_ping  = 1'b0;
    ev_lock  = 1'b0;
    ev_ref   = 1'b0;
    d_old    = lease_deadline - now;
    off_age  = now - off_start;

    switch_level_next   = switch_level;
    dim_level_next      = dim_level;
    lease_armed_next    = lease_armed;
    lease_deadline_next = lease_deadline;
    run_valid_next      = run_valid;
    run_start_next      = run_start;
    off_valid_next      = off_valid;
    off_start_next      = off_start;
    heard_valid_next    = heard_valid;
    last_heard_next     = last_heard;
    lost_flag_next      = lost_flag;
    ping_valid_next     = ping_valid;
    last_ping_next      = last_ping;
    lockout_flag_next   = lockout_flag;

    unique case (item.cmd)
      CMD_SET: begin
        if (lockout_flag) begin
          ev_ref = 1'b1;
        end else begin
          if (item.ssr_write) begin
            switch_level_next = item.ssr_value;
          end
          if (item.dimmer_write) begin
            dim_level_next = item.dimmer_value;
          end
          ttl = (item.ttl_ms == 16'd0) ? {16'd0, cfg.lease_default_ms}
                                       : {16'd0, item.ttl_ms};
          lease_deadline_next = now + ttl;
          lease_armed_next    = 1'b1;
        end
      end
      CMD_STOP: begin
        switch_level_next = 1'b0;
        dim_level_next    = 8'd0;
        lease_armed_next  = 1'b0;
      end
      CMD_PRESENCE: begin
        heard_valid_next = 1'b1;
        last_heard_next  = now;
        lost_flag_next   = 1'b0;
      end
      default: begin
        if (lease_armed && ((d_old == 32'd0) || d_old[31])) begin
          if (!switch_level && (dim_level == 8'd0)) begin
            lease_armed_next = 1'b0;
          end else begin
            switch_level_next = 1'b0;
            dim_level_next    = 8'd0;
            lease_armed_next  = 1'b0;
            ev_lease          = 1'b1;
          end
        end
        if (!heard_valid || ((now - last_heard) > {12'd0, cfg.presence_timeout_ms})) begin
          if (!lost_flag) begin
            lost_flag_next    = 1'b1;
            switch_level_next = 1'b0;
            dim_level_next    = 8'd0;
            lease_armed_next  = 1'b0;
            ev_lost           = 1'b1;
          end
          if (!ping_valid || ((now - last_ping) > {12'd0, cfg.ping_interval_ms})) begin
            ping_valid_next = 1'b1;
            last_ping_next  = now;
            ev_ping         = 1'b1;
          end
        end
        if (switch_level_next || (dim_level_next != 8'd0)) begin
          if ((off_valid && (off_age >= {12'd0, cfg.rearm_gap_ms})) || !run_valid) begin
            run_start_next = now;
            run_valid_next = 1'b1;
          end
          off_valid_next = 1'b0;
          if (!lockout_flag && ((now - run_start_next) > {8'd0, cfg.run_limit_ms})) begin
            lockout_flag_next = 1'b1;
            switch_level_next = 1'b0;
            dim_level_next    = 8'd0;
            lease_armed_next  = 1'b0;
            ev_lock           = 1'b1;
          end
        end else begin
          if (!off_valid) begin
            off_valid_next = 1'b1;
            off_start_next = now;
          end else if (off_age >= {12'd0, cfg.rearm_gap_ms}) begin
            run_valid_next = 1'b0;
          end
        end
      end
    endcase

    d_new = lease_deadline_next - now;

    res.ssr_on           = switch_level_next;
    res.dimmer_level     = dim_level_next;
    res.locked_out       = lockout_flag_next;
    res.peer_lost        = lost_flag_next;
    res.lease_left_ms    = (lease_armed_next && (d_new != 32'd0) && !d_new[31])
                           ? sat16(d_new) : 16'd0;
    res.run_time_ms      = run_valid_next ? sat16(now - run_start_next) : 16'd0;
    res.ev_lease_expired = ev_lease;
    res.ev_presence_lost = ev_lost;
    res.ev_ping_request  = ev_ping;
    res.ev_lockout       = ev_lock;
    res.ev_refused       = ev_ref;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      switch_level   <= 1'b0;
      dim_level      <= 8'd0;
      lease_armed    <= 1'b0;
      lease_deadline <= 32'd0;
      run_valid      <= 1'b0;
      run_start      <= 32'd0;
      off_valid      <= 1'b0;
      off_start      <= 32'd0;
      heard_valid    <= 1'b0;
      last_heard     <= 32'd0;
      lost_flag      <= 1'b1;
      ping_valid     <= 1'b0;
      last_ping      <= 32'd0;
      lockout_flag   <= 1'b0;
    end else if (fire) begin
      switch_level   <= switch_level_next;
      dim_level      <= dim_level_next;
      lease_armed    <= lease_armed_next;
      lease_deadline <= lease_deadline_next;
      run_valid      <= run_valid_next;
      run_start      <= run_start_next;
      off_valid      <= off_valid_next;
      off_start      <= off_start_next;
      heard_valid    <= heard_valid_next;
      last_heard     <= last_heard_next;
      lost_flag      <= lost_flag_next;
      ping_valid     <= ping_valid_next;
      last_ping      <= last_ping_next;
      lockout_flag   <= lockout_flag_next;
    end
  end

endmodule

// ----- hw/rtl/actuator_safety_supervisor.sv -----
// ----------------------------------------------------------------------------
// Actuator safety supervisor
// Guards a switch output and a dimmer output with leases, peer presence
// monitoring and a sticky continuous-run lockout.
// ----------------------------------------------------------------------------
// Each input item carries a command (tick, set, stop, presence heard) and a
// millisecond timestamp. Items enter on the in_valid/in_ready channel and each
// produces exactly one result on the out_valid/out_ready channel, holding the
// output levels, status and the events raised by that item.
// An accepted item lands in an input register; when it advances, the decision
// logic updates the supervisor state and loads the result register, raising
// out_valid. One item is taken per cycle as
// long as the receiver keeps up.
// When the receiver stalls, the result register holds its item and the input
// register holds one more; in_ready then drops until a result is taken.
// The timing limits are written through cfg_we, cfg_index and cfg_data by the
// user only while the block is idle, unenforced; unused indexes are ignored.
// Reset clears the lockout, turns both outputs off, marks the peer lost with a
// ping due, and restores the default timing limits.
// ----------------------------------------------------------------------------
module actuator_safety_supervisor (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  asp_pkg::asp_in_t                  in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output asp_pkg::asp_out_t                 out_data,
  input  logic                              cfg_we,
  input  logic [asp_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [asp_pkg::CfgDataWidth-1:0]  cfg_data
);
  import asp_pkg::*;

  asp_cfg_t cfg;
  asp_in_t  in_q;
  logic     in_valid_q;
  asp_out_t res;
  logic     advance;

  assign advance  = in_valid_q && (!out_valid || out_ready);
  assign in_ready = !in_valid_q || advance;

  asp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  asp_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (advance),
    .item (in_q),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= in_data;
    end
    if (advance) begin
      out_data <= res;
    end
  end

endmodule
